// ----- rtl/sefr_pkg.sv -----
// Shared types and constants for the STX/ETX frame receiver.
package sefr_pkg;

  localparam logic [7:0] STX_BYTE  = 8'h02;
  localparam logic [7:0] ETX_BYTE  = 8'h03;
  localparam logic [7:0] SUM_START = 8'h02;

  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_TYPE    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CHECK_B = 3'd4;
  localparam logic [PHASE_W-1:0] PH_END     = 3'd5;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic       frame_good;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic       message_ready;
  } result_t;

endpackage

// ----- rtl/sefr_deframer.sv -----
// Frame state machine with running Fletcher-8 sums; produces one result per byte.
module sefr_deframer
  import sefr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output result_t    result
);

  logic [PHASE_W-1:0] phase, phase_next;
  logic [7:0] type_reg, type_reg_next;
  logic [7:0] length_reg, length_reg_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] sum_a, sum_a_next;
  logic [7:0] sum_b, sum_b_next;
  logic [7:0] check_a_rx, check_a_rx_next;
  logic [7:0] check_b_rx, check_b_rx_next;
  logic       ready_flag, ready_flag_next;
  logic [7:0] fold_a;
  logic [7:0] fold_b;

  assign fold_a = sum_a + rx_byte;
  assign fold_b = sum_b + fold_a;

  always_comb begin
    phase_next      = phase;
    type_reg_next   = type_reg;
    length_reg_next = length_reg;
    byte_count_next = byte_count;
    sum_a_next      = sum_a;
    sum_b_next      = sum_b;
    check_a_rx_next = check_a_rx;
    check_b_rx_next = check_b_rx;
    ready_flag_next = ready_flag;
    result          = '0;

    unique case (phase)
      PH_IDLE: begin
        if (rx_byte == STX_BYTE) begin
          byte_count_next = '0;
          sum_a_next      = SUM_START;
          sum_b_next      = SUM_START;
          ready_flag_next = 1'b0;
          phase_next      = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_reg_next = rx_byte;
        sum_a_next    = fold_a;
        sum_b_next    = fold_b;
        phase_next    = PH_LENGTH;
      end
      PH_LENGTH: begin
        length_reg_next = rx_byte;
        sum_a_next      = fold_a;
        sum_b_next      = fold_b;
        phase_next      = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (byte_count >= length_reg) begin
          check_a_rx_next = rx_byte;
          phase_next      = PH_CHECK_B;
        end else begin
          result.payload_valid = 1'b1;
          result.payload_byte  = rx_byte;
          result.payload_index = byte_count;
          sum_a_next           = fold_a;
          sum_b_next           = fold_b;
          byte_count_next      = byte_count + 8'd1;
        end
      end
      PH_CHECK_B: begin
        check_b_rx_next = rx_byte;
        phase_next      = PH_END;
      end
      PH_END: begin
        result.frame_done = 1'b1;
        if (rx_byte == ETX_BYTE && sum_a == check_a_rx && sum_b == check_b_rx) begin
          result.frame_good = 1'b1;
          ready_flag_next   = 1'b1;
        end
        phase_next = PH_IDLE;
      end
      default: begin
        // unreachable codes: drop the byte and resync
        byte_count_next = '0;
        ready_flag_next = 1'b0;
        phase_next      = PH_IDLE;
      end
    endcase

    result.frame_type    = type_reg_next;
    result.frame_length  = length_reg_next;
    result.message_ready = ready_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      type_reg   <= '0;
      length_reg <= '0;
      byte_count <= '0;
      sum_a      <= SUM_START;
      sum_b      <= SUM_START;
      check_a_rx <= '0;
      check_b_rx <= '0;
      ready_flag <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      type_reg   <= type_reg_next;
      length_reg <= length_reg_next;
      byte_count <= byte_count_next;
      sum_a      <= sum_a_next;
      sum_b      <= sum_b_next;
      check_a_rx <= check_a_rx_next;
      check_b_rx <= check_b_rx_next;
      ready_flag <= ready_flag_next;
    end
  end

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_END)
    else $error("deframer phase left the legal range");

  a_start_resets_sums: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && rx_byte == STX_BYTE |=>
      sum_a == SUM_START && sum_b == SUM_START && !ready_flag && byte_count == 8'd0)
    else $error("start byte did not restart the frame");

  a_good_needs_done: assert property (@(posedge clk) disable iff (rst)
    result.frame_good |-> result.frame_done && !result.payload_valid)
    else $error("good flag without end of frame");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> byte_count <= length_reg)
    else $error("payload count ran past the frame length");

endmodule

// ----- rtl/sefr_out_reg.sv -----
// Result register between the deframer and the output channel.
module sefr_out_reg
  import sefr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t result_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the beat while stalled; load only when the slot is free or draining
  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ----- rtl/stx_etx_frame_receiver.sv -----
// Top level of the STX/ETX frame receiver with Fletcher-8 check.
// Takes one received byte per beat and returns exactly one result beat for it in the next
// cycle through a result register. A new byte is accepted every cycle unless a result
// waits on a stalled output; the frame state and running sums update as each byte is
// accepted, so sustained throughput is one byte per clock while the output is not
// stalled. Frames are 0x02, type, length, payload, check A, check B, 0x03; payload bytes
// come out with their index and the end position reports whether the frame was good.
module stx_etx_frame_receiver
  import sefr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic       frame_done,
  output logic       frame_good,
  output logic [7:0] frame_type,
  output logic [7:0] frame_length,
  output logic       message_ready
);

  logic    accept;
  result_t core_result;
  result_t out_result;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  sefr_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .result  (core_result)
  );

  sefr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result_in  (core_result),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result_out (out_result)
  );

  assign payload_valid = out_result.payload_valid;
  assign payload_byte  = out_result.payload_byte;
  assign payload_index = out_result.payload_index;
  assign frame_done    = out_result.frame_done;
  assign frame_good    = out_result.frame_good;
  assign frame_type    = out_result.frame_type;
  assign frame_length  = out_result.frame_length;
  assign message_ready = out_result.message_ready;

endmodule

// ----- dv/stx_etx_frame_receiver_test.sv -----
// Testbench for the STX/ETX frame receiver: directed and random framed traffic, scoreboard.
module stx_etx_frame_receiver_test;
  import sefr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int FRAME_BYTE_GOAL = 1950;
  localparam int DRAIN_CYCLES = 4;

  typedef enum {FR_GOOD, FR_BAD_END, FR_BAD_A, FR_BAD_B} frame_kind_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       frame_done;
  logic       frame_good;
  logic [7:0] frame_type;
  logic [7:0] frame_length;
  logic       message_ready;

  // Deframer state mirrored by the predictor
  logic [2:0] st_phase = PH_IDLE;
  logic [7:0] st_type = 8'h00;
  logic [7:0] st_len = 8'h00;
  logic [7:0] st_count = 8'h00;
  logic [7:0] st_sum_a = SUM_START;
  logic [7:0] st_sum_b = SUM_START;
  logic [7:0] st_chk_a = 8'h00;
  logic [7:0] st_chk_b = 8'h00;
  logic       st_ready = 1'b0;

  result_t receiver_outputs_q[$];
  bit      no_idle = 1'b0;
  int      mismatches = 0;
  int      cycle_count = 0;
  int      frame_bytes = 0;
  int      bytes_in = 0;
  int      frames_ended = 0;
  int      frames_good = 0;
  int      payload_beats = 0;

  stx_etx_frame_receiver u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_valid(payload_valid),
    .payload_byte (payload_byte),
    .payload_index(payload_index),
    .frame_done   (frame_done),
    .frame_good   (frame_good),
    .frame_type   (frame_type),
    .frame_length (frame_length),
    .message_ready(message_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void fold_sum(logic [7:0] b);
    st_sum_a = st_sum_a + b;
    st_sum_b = st_sum_b + st_sum_a;
  endfunction

  // Advance the mirrored deframer by one byte and return the beat it produces.
  function automatic result_t deframe_byte(logic [7:0] b);
    result_t r;
    r = '0;
    case (st_phase)
      PH_IDLE: begin
        if (b == STX_BYTE) begin
          st_count = 8'h00;
          st_sum_a = SUM_START;
          st_sum_b = SUM_START;
          st_ready = 1'b0;
          st_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        st_type = b;
        fold_sum(b);
        st_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        st_len = b;
        fold_sum(b);
        st_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (st_count >= st_len) begin
          st_chk_a = b;
          st_phase = PH_CHECK_B;
        end else begin
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          r.payload_index = st_count;
          fold_sum(b);
          st_count = st_count + 8'd1;
        end
      end
      PH_CHECK_B: begin
        st_chk_b = b;
        st_phase = PH_END;
      end
      PH_END: begin
        r.frame_done = 1'b1;
        if (b == ETX_BYTE && st_sum_a == st_chk_a && st_sum_b == st_chk_b) begin
          r.frame_good = 1'b1;
          st_ready = 1'b1;
        end
        st_phase = PH_IDLE;
      end
      default: begin
        st_count = 8'h00;
        st_ready = 1'b0;
        st_phase = PH_IDLE;
      end
    endcase
    r.frame_type = st_type;
    r.frame_length = st_len;
    r.message_ready = st_ready;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare the result beat first so a beat can never match an input taken at the same edge.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (receiver_outputs_q.size() == 0) begin
          $error("result beat with no expected beat pending");
          mismatches++;
        end else begin
          want = receiver_outputs_q.pop_front();
          check_field("payload_valid", 8'(want.payload_valid), 8'(payload_valid));
          check_field("payload_byte", want.payload_byte, payload_byte);
          check_field("payload_index", want.payload_index, payload_index);
          check_field("frame_done", 8'(want.frame_done), 8'(frame_done));
          check_field("frame_good", 8'(want.frame_good), 8'(frame_good));
          check_field("frame_type", want.frame_type, frame_type);
          check_field("frame_length", want.frame_length, frame_length);
          check_field("message_ready", 8'(want.message_ready), 8'(message_ready));
          if (want.frame_done) frames_ended++;
          if (want.frame_good) frames_good++;
          if (want.payload_valid) payload_beats++;
        end
      end
      if (in_valid && !in_stall) begin
        receiver_outputs_q.push_back(deframe_byte(rx_byte));
        bytes_in++;
      end
    end
  end

  // Output side: hold stall for a random number of cycles before each beat.
  initial begin
    int hold;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Called and returns at a falling edge; valid stays high when the next beat follows at once.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_frame(logic [7:0] ftype, logic [7:0] flen, frame_kind_t kind,
                            bit fixed_fill);
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    logic [7:0] data;
    logic [7:0] end_byte;
    int i;
    sum_a = SUM_START;
    sum_b = SUM_START;
    send_byte(STX_BYTE);
    send_byte(ftype);
    sum_a = sum_a + ftype;
    sum_b = sum_b + sum_a;
    send_byte(flen);
    sum_a = sum_a + flen;
    sum_b = sum_b + sum_a;
    for (i = 0; i < flen; i++) begin
      data = fixed_fill ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
      send_byte(data);
      sum_a = sum_a + data;
      sum_b = sum_b + sum_a;
    end
    if (kind == FR_BAD_A) sum_a = sum_a ^ 8'($urandom_range(1, 255));
    if (kind == FR_BAD_B) sum_b = sum_b ^ 8'($urandom_range(1, 255));
    end_byte = ETX_BYTE;
    if (kind == FR_BAD_END) begin
      do end_byte = 8'($urandom_range(0, 255)); while (end_byte == ETX_BYTE);
    end
    send_byte(sum_a);
    send_byte(sum_b);
    send_byte(end_byte);
    frame_bytes += 6 + flen;
  endtask

  task automatic test_idle_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ETX_BYTE);
  endtask

  task automatic test_zero_length();
    send_frame(8'hFF, 8'h00, FR_GOOD, 1'b1);
  endtask

  // Ready must survive idle bytes, then drop on the next start byte and stay low on a bad end.
  task automatic test_sticky_ready();
    send_byte(8'h55);
    send_byte(8'hAA);
    send_frame(8'h80, 8'h00, FR_BAD_END, 1'b1);
  endtask

  task automatic test_payload_extremes();
    send_frame(8'h00, 8'h02, FR_GOOD, 1'b1);
  endtask

  task automatic test_longest_frame();
    send_frame(8'($urandom_range(0, 255)), 8'hFF, FR_GOOD, 1'b0);
  endtask

  task automatic test_random_frames();
    int pick;
    int n;
    int i;
    logic [7:0] flen;
    frame_kind_t kind;
    while (frame_bytes < FRAME_BYTE_GOAL) begin
      no_idle = ($urandom_range(0, 99) < 15);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // stray bytes between frames, sometimes a lone start byte that breaks the next frame
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 99) < 25) send_byte(STX_BYTE);
          else send_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 1) flen = 8'($urandom_range(128, 255));
        else if (pick < 10) flen = 8'($urandom_range(9, 64));
        else flen = 8'($urandom_range(0, 8));
        pick = $urandom_range(0, 99);
        if (pick < 70) kind = FR_GOOD;
        else if (pick < 80) kind = FR_BAD_END;
        else if (pick < 90) kind = FR_BAD_A;
        else kind = FR_BAD_B;
        send_frame(8'($urandom_range(0, 255)), flen, kind, 1'b0);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_idle_noise();
    test_zero_length();
    test_sticky_ready();
    test_payload_extremes();
    test_longest_frame();
    test_random_frames();
    in_valid = 1'b0;
    while (receiver_outputs_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bytes (%0d inside frames); checked %0d payload beats", bytes_in,
             frame_bytes, payload_beats);
    $display("%0d frame ends seen, %0d of them good; %0d mismatches", frames_ended,
             frames_good, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
